// ===== src/lpn_pkg.sv =====
// Shared types and constants for the length-prefixed NAL to Annex B converter.
// Used by lpn_front, lpn_queue, lpn_back and the top level.
package lpn_pkg;

    localparam int QueueDepth = 4;
    localparam int ScLongLen  = 4;
    localparam int ScShortLen = 3;
    localparam logic [1:0] LengthSizeReset = 2'd3;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic        sample_start;
        logic [31:0] sample_len;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       sample_end;
        logic       sample_mismatch;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_DATA     = 2'd0,
        CMD_SC_LONG  = 2'd1,
        CMD_SC_SHORT = 2'd2,
        CMD_STATUS   = 2'd3
    } cmd_kind_t;

    // One classified input item: what the back end must emit for it.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       sample_end;
        logic       mismatch;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_xfer_t;

endpackage

// ===== src/length_prefixed_nal_to_annexb.sv =====
// Length-prefixed NAL to Annex B converter, top level.
// Takes one sample byte per transfer on the item channel (valid/ready) and
// gives Annex B bytes on the result channel (valid/ready). Each byte carries
// sample_start and, with it, sample_len. Length prefixes of 1 to 4 bytes
// (cfg_data = bytes minus one) become 00 00 00 01 for the first NAL unit of a
// sample and 00 00 01 after that; payload bytes pass through unchanged.
// The last result of a sample carries sample_end, and sample_mismatch when the
// sample stops inside a length field or payload.
// With the queue and output register empty, the first result of an item passes
// through the command queue and the output register before it is presented.
// One payload byte per cycle while the receiver keeps up; a prefix byte that
// completes a length becomes four or three result bytes, as the back end has a
// single result port. A four-entry command queue decouples input from output,
// so input keeps flowing while a start code drains and stalls only once it fills.
// A receiver stall holds the output register; the queue fills, then item_ready
// drops. Reset empties the queue and output register and sets the length size
// to four bytes. Write cfg_data only while no item is in flight.
module length_prefixed_nal_to_annexb
    import lpn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  in_item_t   item,
    output logic       result_valid,
    input  logic       result_ready,
    output out_item_t  result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    cmd_xfer_t q_push;
    cmd_xfer_t q_head;
    logic      q_full;
    logic      q_pop;

    lpn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_push     (q_push)
    );

    lpn_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .head  (q_head),
        .pop   (q_pop)
    );

    lpn_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        q_push.valid |-> !q_full)
        else $error("command pushed into a full queue");

    a_status_closes_sample : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.byte_valid) |-> (result.sample_end && result.last_of_run))
        else $error("status-only result without sample end");

    a_mismatch_on_end : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.sample_mismatch) |-> result.sample_end)
        else $error("mismatch flagged away from sample end");

    a_pop_needs_head : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("queue popped while empty");

endmodule

// ===== src/lpn_front.sv =====
// Front end: takes input transfers, tracks sample and NAL length state, and
// pushes one command per item that produces results. Depends on lpn_pkg.
module lpn_front
    import lpn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  in_item_t   item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    input  logic       q_full,
    output cmd_xfer_t  q_push
);

    logic [1:0]  length_size_minus_one_reg;
    logic        phase_reg, phase_next;
    logic [31:0] length_accum_reg, length_accum_next;
    logic [1:0]  length_seen_reg, length_seen_next;
    logic [31:0] payload_rem_reg, payload_rem_next;
    logic [31:0] sample_rem_reg, sample_rem_next;
    logic        first_nal_reg, first_nal_next;

    logic        accept;
    logic        eff_phase;
    logic [31:0] eff_accum;
    logic [1:0]  eff_seen;
    logic [31:0] eff_payload;
    logic [31:0] eff_sample;
    logic        eff_first;
    logic [31:0] sample_dec;
    logic        ended;
    logic [2:0]  count;
    logic [31:0] accum_shift;
    logic [31:0] payload_dec;
    logic        mis;
    logic        emit;
    cmd_kind_t   kind;

    assign item_ready = !q_full;
    assign cfg_ready  = 1'b1;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        // a sample start reloads the counters before the byte is classified
        eff_phase   = item.sample_start ? 1'b0  : phase_reg;
        eff_accum   = item.sample_start ? '0    : length_accum_reg;
        eff_seen    = item.sample_start ? '0    : length_seen_reg;
        eff_payload = item.sample_start ? '0    : payload_rem_reg;
        eff_sample  = item.sample_start ? item.sample_len : sample_rem_reg;
        eff_first   = item.sample_start ? 1'b1  : first_nal_reg;

        sample_dec  = eff_sample - 32'd1;
        ended       = (eff_sample == 32'd1);
        count       = {1'b0, eff_seen} + 3'd1;
        accum_shift = {eff_accum[23:0], item.in_byte};
        payload_dec = eff_payload - 32'd1;

        phase_next        = eff_phase;
        length_accum_next = eff_accum;
        length_seen_next  = eff_seen;
        payload_rem_next  = eff_payload;
        sample_rem_next   = eff_sample;
        first_nal_next    = eff_first;
        kind              = CMD_STATUS;
        mis               = 1'b0;
        emit              = 1'b0;

        if (eff_sample != 32'd0)
        begin
            sample_rem_next = sample_dec;
            if (!eff_phase)
            begin
                if (count >= ({1'b0, length_size_minus_one_reg} + 3'd1))
                begin
                    kind              = eff_first ? CMD_SC_LONG : CMD_SC_SHORT;
                    emit              = 1'b1;
                    first_nal_next    = 1'b0;
                    payload_rem_next  = accum_shift;
                    phase_next        = (accum_shift != 32'd0);
                    length_accum_next = '0;
                    length_seen_next  = '0;
                    mis               = (accum_shift != 32'd0);
                end
                else
                begin
                    length_accum_next = accum_shift;
                    length_seen_next  = count[1:0];
                    emit              = ended;
                    mis               = 1'b1;
                end
            end
            else
            begin
                kind             = CMD_DATA;
                emit             = 1'b1;
                payload_rem_next = payload_dec;
                phase_next       = (payload_dec != 32'd0);
                mis              = (payload_dec != 32'd0);
            end

            if (ended)
            begin
                phase_next        = 1'b0;
                length_accum_next = '0;
                length_seen_next  = '0;
                payload_rem_next  = '0;
                first_nal_next    = 1'b1;
            end
        end

        q_push.valid          = accept && emit;
        q_push.cmd.kind       = kind;
        q_push.cmd.data       = item.in_byte;
        q_push.cmd.sample_end = ended;
        q_push.cmd.mismatch   = ended && mis;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_size_minus_one_reg <= LengthSizeReset;
            phase_reg                 <= 1'b0;
            length_accum_reg          <= '0;
            length_seen_reg           <= '0;
            payload_rem_reg           <= '0;
            sample_rem_reg            <= '0;
            first_nal_reg             <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                length_size_minus_one_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg        <= phase_next;
                length_accum_reg <= length_accum_next;
                length_seen_reg  <= length_seen_next;
                payload_rem_reg  <= payload_rem_next;
                sample_rem_reg   <= sample_rem_next;
                first_nal_reg    <= first_nal_next;
            end
        end
    end

endmodule

// ===== src/lpn_queue.sv =====
// Short command queue between the front and back ends.
// Depends on lpn_pkg for the command type and depth.
module lpn_queue
    import lpn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_xfer_t push,
    output logic      full,
    output cmd_xfer_t head,
    input  logic      pop
);

    localparam int PtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CountW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0]   LastPtr = PtrW'(QueueDepth - 1);
    localparam logic [CountW-1:0] Full    = CountW'(QueueDepth);

    cmd_t            mem [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == Full);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/lpn_back.sv =====
// Back end: expands queued commands into result transfers (start codes,
// payload bytes, status) through an output register. Depends on lpn_pkg.
module lpn_back
    import lpn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_xfer_t head,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    localparam logic [1:0] LongLast  = 2'(ScLongLen - 1);
    localparam logic [1:0] ShortLast = 2'(ScShortLen - 1);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    logic       run_last;
    logic       load;

    always_comb
    begin
        case (head.cmd.kind)
            CMD_SC_LONG:  run_last = (idx_reg == LongLast);
            CMD_SC_SHORT: run_last = (idx_reg == ShortLast);
            default:      run_last = 1'b1;
        endcase

        out_next.out_byte        = '0;
        out_next.byte_valid      = (head.cmd.kind != CMD_STATUS);
        out_next.last_of_run     = run_last;
        out_next.sample_end      = run_last && head.cmd.sample_end;
        out_next.sample_mismatch = run_last && head.cmd.mismatch;
        case (head.cmd.kind) inside
            CMD_DATA:                  out_next.out_byte = head.cmd.data;
            CMD_SC_LONG, CMD_SC_SHORT: out_next.out_byte = run_last ? 8'd1 : 8'd0;
            default:                   out_next.out_byte = '0;
        endcase

        // refill the output register from a queued command whenever it is empty or being drained
        load = head.valid && (!out_valid_reg || result_ready);
        pop  = load && run_last;

        idx_next = idx_reg;
        if (load)
        begin
            idx_next = run_last ? 2'd0 : idx_reg + 2'd1;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
